/* rtl/core/keyed_duration_stats_table_macros.svh */
// Assertion macros used by the stats table RTL
`ifndef KEYED_DURATION_STATS_TABLE_MACROS_SVH
`define KEYED_DURATION_STATS_TABLE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define KDST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KDST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/kdst_pkg.sv */
// Types and constants for the keyed duration stats table
package kdst_pkg;

    localparam int KEY_W   = 48;
    localparam int TICK_W  = 64;
    localparam int COUNT_W = 32;
    localparam int IDX_W   = 4;
    localparam int USED_W  = 5;
    localparam int STAT_W  = 3;

    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_UPDATED    = 3'd0,
        ST_ADDED      = 3'd1,
        ST_FULL       = 3'd2,
        ST_READ_OK    = 3'd3,
        ST_READ_EMPTY = 3'd4
    } status_t;

    typedef struct packed {
        logic                func;
        logic [KEY_W-1:0]    key;
        logic [TICK_W-1:0]   duration;
        logic [IDX_W-1:0]    read_index;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [IDX_W-1:0]    entry_index;
        logic [KEY_W-1:0]    entry_key;
        logic [TICK_W-1:0]   total_ticks;
        logic [COUNT_W-1:0]  call_count;
        logic [USED_W-1:0]   entries_used;
    } rsp_t;

    // request travelling down the cell row, collecting the hit on its way
    typedef struct packed {
        logic                valid;
        req_t                req;
        logic                hit;
        logic                added;
        logic [IDX_W-1:0]    hit_index;
        logic [KEY_W-1:0]    hit_key;
        logic [TICK_W-1:0]   hit_total;
        logic [COUNT_W-1:0]  hit_count;
    } flow_t;

endpackage

/* rtl/core/kdst_cell.sv */
// One table entry with its compare/accumulate logic and a stage of the request row
module kdst_cell
    import kdst_pkg::*;
#(
    parameter int POS    = 0,
    parameter int FILL_W = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [FILL_W-1:0] fill,
    input  flow_t             flow_in,
    output flow_t             flow_out
);

    // only the first sixteen positions can be addressed by a read
    localparam bit RD_REACH = (POS < (1 << IDX_W));

    logic [KEY_W-1:0]   key_reg,   key_next;
    logic [TICK_W-1:0]  total_reg, total_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    flow_t              flow_reg,  flow_next;

    logic               filled;
    logic               at_tail;
    logic               is_upd;
    logic               match;
    logic               append;
    logic               rd_sel;
    logic [TICK_W-1:0]  sum;
    logic [COUNT_W-1:0] count_inc;

    always_comb
    begin
        filled    = FILL_W'(POS) < fill;
        at_tail   = FILL_W'(POS) == fill;
        is_upd    = flow_in.valid && (flow_in.req.func == FUNC_UPDATE) && !flow_in.hit;
        match     = is_upd && filled && (key_reg == flow_in.req.key);
        append    = is_upd && at_tail;
        rd_sel    = flow_in.valid && (flow_in.req.func == FUNC_READ) && filled && RD_REACH
                    && (flow_in.req.read_index == IDX_W'(POS));
        sum       = total_reg + flow_in.req.duration;
        count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;

        key_next   = key_reg;
        total_next = total_reg;
        count_next = count_reg;
        flow_next  = flow_in;

        if (match)
        begin
            total_next          = sum;
            count_next          = count_inc;
            flow_next.hit       = 1'b1;
            flow_next.hit_index = IDX_W'(POS);
            flow_next.hit_key   = key_reg;
            flow_next.hit_total = sum;
            flow_next.hit_count = count_inc;
        end
        else if (append)
        begin
            key_next            = flow_in.req.key;
            total_next          = flow_in.req.duration;
            count_next          = COUNT_W'(1);
            flow_next.hit       = 1'b1;
            flow_next.added     = 1'b1;
            flow_next.hit_index = IDX_W'(POS);
            flow_next.hit_key   = flow_in.req.key;
            flow_next.hit_total = flow_in.req.duration;
            flow_next.hit_count = COUNT_W'(1);
        end
        else if (rd_sel)
        begin
            flow_next.hit       = 1'b1;
            flow_next.hit_index = IDX_W'(POS);
            flow_next.hit_key   = key_reg;
            flow_next.hit_total = total_reg;
            flow_next.hit_count = count_reg;
        end
    end

    // entry contents need no reset: unfilled entries are never looked at
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        total_reg <= total_next;
        count_reg <= count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_reg <= '0;
        end
        else
        begin
            flow_reg <= flow_next;
        end
    end

    assign flow_out = flow_reg;

endmodule

/* rtl/core/keyed_duration_stats_table.sv */
// Each request walks the cell row, one register per cell, then the pending-result and output registers.
// One item in flight at a time: no new input beat is taken until the last result moves to the output.
// The next input beat is taken while a finished result still waits at the output.
// Reset clears the fill count and all handshake state; entry contents are left as they are.
// No clearing pass: unfilled entries are never read.
`include "keyed_duration_stats_table_macros.svh"

module keyed_duration_stats_table
    import kdst_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int FILL_W = $clog2(ENTRIES + 1);

    flow_t             chain [ENTRIES+1];
    flow_t             end_flow;

    logic              busy_reg,      busy_next;
    logic [FILL_W-1:0] fill_reg,      fill_next;
    rsp_t              pend_reg,      pend_next;
    logic              pend_valid_reg, pend_valid_next;
    rsp_t              rsp_reg,       rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    logic              accept;
    logic              out_load;
    rsp_t              result;

    assign accept    = req_valid && !busy_reg;
    assign req_stall = busy_reg;

    always_comb
    begin
        chain[0]           = '0;
        chain[0].valid     = accept;
        chain[0].req       = req;
    end

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        kdst_cell #(
            .POS    (g),
            .FILL_W (FILL_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .fill     (fill_reg),
            .flow_in  (chain[g]),
            .flow_out (chain[g+1])
        );
    end

    assign end_flow = chain[ENTRIES];

    always_comb
    begin
        fill_next = fill_reg;
        if (end_flow.valid && end_flow.added)
        begin
            fill_next = fill_reg + 1'b1;
        end

        result              = '0;
        result.entries_used = USED_W'(fill_next);
        if (end_flow.req.func == FUNC_READ)
        begin
            if (end_flow.hit)
            begin
                result.status      = ST_READ_OK;
                result.entry_index = end_flow.hit_index;
                result.entry_key   = end_flow.hit_key;
                result.total_ticks = end_flow.hit_total;
                result.call_count  = end_flow.hit_count;
            end
            else
            begin
                result.status      = ST_READ_EMPTY;
                result.entry_index = end_flow.req.read_index;
            end
        end
        else if (end_flow.hit)
        begin
            result.status      = end_flow.added ? ST_ADDED : ST_UPDATED;
            result.entry_index = end_flow.hit_index;
            result.entry_key   = end_flow.hit_key;
            result.total_ticks = end_flow.hit_total;
            result.call_count  = end_flow.hit_count;
        end
        else
        begin
            result.status = ST_FULL;
        end
    end

    always_comb
    begin
        out_load        = pend_valid_reg && (!rsp_valid_reg || !rsp_stall);
        busy_next       = busy_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (out_load)
        begin
            rsp_next        = pend_reg;
            rsp_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
            busy_next       = 1'b0;
        end
        if (end_flow.valid)
        begin
            pend_next       = result;
            pend_valid_next = 1'b1;
        end
        if (accept)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            fill_reg       <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            fill_reg       <= fill_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `KDST_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= FILL_W'(ENTRIES), "fill count above table size")
    `KDST_ASSERT_NOW(a_end_busy, end_flow.valid, busy_reg, "request left the row while idle")
    `KDST_ASSERT_NOW(a_pend_free, end_flow.valid, !pend_valid_reg, "result holding stage overrun")
    `KDST_ASSERT_NEXT(a_fill_step, end_flow.valid && end_flow.added, fill_reg == FILL_W'($past(fill_reg) + 1'b1), "append did not bump fill count")

endmodule
